// ===== src/button_click_mode_controller_unit_macros.svh =====
// assertion helpers for the controller core module
`ifndef BUTTON_CLICK_MODE_CONTROLLER_UNIT_MACROS_SVH
`define BUTTON_CLICK_MODE_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bcm_pkg.sv =====
package bcm_pkg;

   // elapsed counter and register widths
   localparam int COUNT_BITS = 16;
   localparam int CNT_W = COUNT_BITS;
   localparam int CFG_W = 16;
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int FRAME_COUNT = 4;
   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int CSR_IDX_W = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_HOLD = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_PERIOD = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_INFO_TIMEOUT = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_STALL = CSR_IDX_W'(5);

   // register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
   localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = CFG_W'(300);
   localparam logic [CFG_W-1:0] SEND_HOLD_RST = CFG_W'(800);
   localparam logic [CFG_W-1:0] SPIN_PERIOD_RST = CFG_W'(500);
   localparam logic [CFG_W-1:0] INFO_TIMEOUT_RST = CFG_W'(3000);
   localparam logic [CFG_W-1:0] STALL_RST = CFG_W'(60000);

   typedef enum logic [1:0] {
      MD_STANDBY = 2'd0,
      MD_DETECT  = 2'd1,
      MD_INFO    = 2'd2
   } mode_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] double_click_ticks;
      logic [CFG_W-1:0] send_hold_ticks;
      logic [CFG_W-1:0] spin_period_ticks;
      logic [CFG_W-1:0] info_timeout_ticks;
      logic [CFG_W-1:0] stall_ticks;
   } cfg_type;

   typedef struct packed {
      logic button_level;
      logic packet_heard;
      logic poll_heard;
   } item_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic               send_screen;
      logic [FRAME_W-1:0] spinner_frame;
      logic               reply_request;
      logic               reply_shown;
      logic               radio_reinit;
      logic               redraw;
   } result_type;

   // saturating tick counter
   function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + CNT_W'(1);
   endfunction

   // bring counters and thresholds to a common compare width
   function automatic logic [CMP_W-1:0] cnt_ext(logic [CNT_W-1:0] c);
      return CMP_W'(c);
   endfunction

   function automatic logic [CMP_W-1:0] cfg_ext(logic [CFG_W-1:0] c);
      return CMP_W'(c);
   endfunction

endpackage

// ===== src/bcm_csr.sv =====
module bcm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [bcm_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [bcm_pkg::CFG_W-1:0]       wr_data,
   output bcm_pkg::cfg_type                cfg
);
   import bcm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DEBOUNCE:     cfg_in.debounce_ticks = wr_data;
            CSR_DOUBLE_CLICK: cfg_in.double_click_ticks = wr_data;
            CSR_SEND_HOLD:    cfg_in.send_hold_ticks = wr_data;
            CSR_SPIN_PERIOD:  cfg_in.spin_period_ticks = wr_data;
            CSR_INFO_TIMEOUT: cfg_in.info_timeout_ticks = wr_data;
            CSR_STALL:        cfg_in.stall_ticks = wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RST;
         cfg_ff.double_click_ticks <= DOUBLE_CLICK_RST;
         cfg_ff.send_hold_ticks <= SEND_HOLD_RST;
         cfg_ff.spin_period_ticks <= SPIN_PERIOD_RST;
         cfg_ff.info_timeout_ticks <= INFO_TIMEOUT_RST;
         cfg_ff.stall_ticks <= STALL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/bcm_core.sv =====
module bcm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  bcm_pkg::item_type    item,
   input  bcm_pkg::cfg_type     cfg,
   output bcm_pkg::result_type  res
);
   import bcm_pkg::*;
   `include "button_click_mode_controller_unit_macros.svh"

   logic               prev_ff, prev_in;
   logic               stable_ff, stable_in;
   logic               awaiting_ff, awaiting_in;
   logic               hold_ff, hold_in;
   mode_type           mode_ff, mode_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]   debounce_ff, debounce_in;
   logic [CNT_W-1:0]   click_ff, click_in;
   logic [CNT_W-1:0]   hold_cnt_ff, hold_cnt_in;
   logic [CNT_W-1:0]   spin_ff, spin_in;
   logic [CNT_W-1:0]   info_ff, info_in;
   logic [CNT_W-1:0]   silence_ff, silence_in;
   logic               req, shown, reinit, redraw;

   // one tick of the controller
   always_comb begin
      debounce_in = bump(debounce_ff);
      click_in = bump(click_ff);
      hold_cnt_in = bump(hold_cnt_ff);
      spin_in = bump(spin_ff);
      info_in = bump(info_ff);
      silence_in = bump(silence_ff);
      prev_in = item.button_level;
      stable_in = stable_ff;
      awaiting_in = awaiting_ff;
      hold_in = hold_ff;
      mode_in = mode_ff;
      frame_in = frame_ff;
      req = 1'b0;
      shown = 1'b0;
      reinit = 1'b0;
      redraw = 1'b0;

      // packet and poll
      if (item.packet_heard) begin
         silence_in = '0;
         if (item.poll_heard) begin
            req = 1'b1;
            if (mode_ff != MD_INFO) begin
               mode_in = MD_DETECT;
               shown = 1'b1;
               hold_in = 1'b1;
               hold_cnt_in = '0;
               redraw = 1'b1;
            end
         end
      end

      // radio silence check
      if (cnt_ext(silence_in) > cfg_ext(cfg.stall_ticks)) begin
         reinit = 1'b1;
         silence_in = '0;
      end

      // debounce and double click
      if (item.button_level != prev_ff) begin
         debounce_in = '0;
      end
      if (cnt_ext(debounce_in) > cfg_ext(cfg.debounce_ticks) &&
          item.button_level != stable_ff) begin
         stable_in = item.button_level;
         if (!item.button_level) begin
            if (awaiting_ff &&
                cnt_ext(click_in) < cfg_ext(cfg.double_click_ticks)) begin
               awaiting_in = 1'b0;
               mode_in = MD_INFO;
               info_in = '0;
               redraw = 1'b1;
            end else begin
               awaiting_in = 1'b1;
               click_in = '0;
            end
         end
      end

      // single click once the window runs out
      if (awaiting_in && cnt_ext(click_in) >= cfg_ext(cfg.double_click_ticks)) begin
         awaiting_in = 1'b0;
         if (mode_in == MD_STANDBY) begin
            mode_in = MD_DETECT;
            hold_in = 1'b0;
            frame_in = '0;
            spin_in = '0;
         end else begin
            mode_in = MD_STANDBY;
         end
         redraw = 1'b1;
      end

      // per-mode timers
      case (mode_in)
         MD_DETECT: begin
            if (hold_in) begin
               if (cnt_ext(hold_cnt_in) > cfg_ext(cfg.send_hold_ticks)) begin
                  hold_in = 1'b0;
                  frame_in = '0;
                  spin_in = '0;
                  redraw = 1'b1;
               end
            end else if (cnt_ext(spin_in) > cfg_ext(cfg.spin_period_ticks)) begin
               frame_in = frame_in + FRAME_W'(1);
               spin_in = '0;
               redraw = 1'b1;
            end
         end
         MD_INFO: begin
            if (cnt_ext(info_in) >= cfg_ext(cfg.info_timeout_ticks)) begin
               mode_in = MD_STANDBY;
               redraw = 1'b1;
            end
         end
         default: begin
            mode_in = mode_in;
         end
      endcase
   end

   // result of this tick
   always_comb begin
      res.mode = mode_in;
      res.send_screen = (mode_in == MD_DETECT) ? hold_in : 1'b0;
      res.spinner_frame = frame_in;
      res.reply_request = req;
      res.reply_shown = shown;
      res.radio_reinit = reinit;
      res.redraw = redraw;
   end

   // state update, one tick per item
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b1;
         stable_ff <= 1'b1;
         awaiting_ff <= 1'b0;
         hold_ff <= 1'b0;
         mode_ff <= MD_STANDBY;
         frame_ff <= '0;
         debounce_ff <= '0;
         click_ff <= '0;
         hold_cnt_ff <= '0;
         spin_ff <= '0;
         info_ff <= '0;
         silence_ff <= '0;
      end else if (step_en) begin
         prev_ff <= prev_in;
         stable_ff <= stable_in;
         awaiting_ff <= awaiting_in;
         hold_ff <= hold_in;
         mode_ff <= mode_in;
         frame_ff <= frame_in;
         debounce_ff <= debounce_in;
         click_ff <= click_in;
         hold_cnt_ff <= hold_cnt_in;
         spin_ff <= spin_in;
         info_ff <= info_in;
         silence_ff <= silence_in;
      end
   end

   `BCM_ASSERT_IMP(a_shown_needs_req, clock, reset, res.reply_shown, res.reply_request, "shown w/o request")
   `BCM_ASSERT_IMP(a_screen_in_detect, clock, reset, res.send_screen, res.mode == MD_DETECT, "screen outside detect")
   `BCM_ASSERT_NXT(a_shown_holds, clock, reset, step_en && res.reply_shown, hold_ff, "shown reply did not start the hold")
   `BCM_ASSERT_NXT(a_silence_clear, clock, reset, step_en && (item.packet_heard || res.radio_reinit), silence_ff == '0, "silence counter not restarted")

endmodule

// ===== src/button_click_mode_controller_unit.sv =====
// Button click mode controller: debounces an active-low button, sorts presses
// into single and double clicks, and runs the standby/detect/info modes.
// req_ channel: one item per millisecond tick (button level, packet, poll).
// rsp_ channel: exactly one result item per request item, in order.
// csr_ channel: register writes (index, data), always ready; only write it
//   while no item is in flight. Indexes beyond the register list are dropped.
// Data path: an item is held in the input register, its result is computed
//   there and lands in the output register once the output register is free.
// Throughput: one item per cycle while rsp_ready stays high, as the tick update
//   of the mode state between the input and output registers is combinational.
// Stall: when rsp_ready is low the result holds; the input register still
//   takes one more item, then req_ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, restores the
//   register defaults and returns the controller to standby, button released.
module button_click_mode_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_button_level,
   input  logic                            req_packet_heard,
   input  logic                            req_poll_heard,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_mode,
   output logic                            rsp_send_screen,
   output logic [bcm_pkg::FRAME_W-1:0]     rsp_spinner_frame,
   output logic                            rsp_reply_request,
   output logic                            rsp_reply_shown,
   output logic                            rsp_radio_reinit,
   output logic                            rsp_redraw,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bcm_pkg::CFG_W-1:0]       csr_data
);
   import bcm_pkg::*;

   logic       in_valid_ff;
   item_type   item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type res;
   cfg_type    cfg;
   logic       advance;

   // handshake: the input register moves on whenever the output is free
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   bcm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   bcm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.button_level <= req_button_level;
         item_ff.packet_heard <= req_packet_heard;
         item_ff.poll_heard <= req_poll_heard;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mode = rsp_ff.mode;
   assign rsp_send_screen = rsp_ff.send_screen;
   assign rsp_spinner_frame = rsp_ff.spinner_frame;
   assign rsp_reply_request = rsp_ff.reply_request;
   assign rsp_reply_shown = rsp_ff.reply_shown;
   assign rsp_radio_reinit = rsp_ff.radio_reinit;
   assign rsp_redraw = rsp_ff.redraw;

endmodule

// ===== tb/tb_button_click_mode_controller_unit.sv =====
module tb_button_click_mode_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bcm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int DRAIN_SLACK = 8;
   localparam int STEP_ROWS = 24;
   localparam int RETUNE_ROW = 3;
   localparam int PHASES = 7;

   // indexes past the register list, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_STALL + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   // directed rows: item {level, packet, poll}, typed flag, typed result
   typedef struct packed {
      item_type   tick;
      logic       typed;
      result_type want;
   } step_row_type;

   typedef struct packed {
      cfg_type cfg;
      int      n_items;
      int      pkt_pct;
      int      tx_idle;
      int      rx_stall;
      bit      squeeze;
      bit      stray;
      bit      long_quiet;
   } phase_type;

   localparam result_type QUIET_STANDBY = '{mode: MD_STANDBY, default: '0};
   localparam result_type POLL_TAKEN = '{mode: MD_DETECT, send_screen: 1'b1,
      spinner_frame: '0, reply_request: 1'b1, reply_shown: 1'b1, radio_reinit: 1'b0,
      redraw: 1'b1};

   // short timers so every mode change fits in a few items
   localparam cfg_type TUNE_CFG = '{debounce_ticks: 16'd0, double_click_ticks: 16'd6,
      send_hold_ticks: 16'd8, spin_period_ticks: 16'd0, info_timeout_ticks: 16'd4,
      stall_ticks: 16'd5};

   localparam step_row_type STEPS [STEP_ROWS] = '{
      '{3'b100, 1'b1, QUIET_STANDBY},   // idle tick right after reset
      '{3'b111, 1'b1, POLL_TAKEN},      // poll in standby enters detect, holds screen
      '{3'b101, 1'b0, '0},              // poll flag without a packet
      '{3'b000, 1'b0, '0},              // short timers from here on
      '{3'b000, 1'b0, '0},              // first press taken
      '{3'b100, 1'b0, '0},
      '{3'b110, 1'b0, '0},
      '{3'b000, 1'b0, '0},
      '{3'b000, 1'b0, '0},              // second press: info, held screen hidden
      '{3'b111, 1'b0, '0},              // poll in info is answered quietly
      '{3'b100, 1'b0, '0},
      '{3'b100, 1'b0, '0},
      '{3'b100, 1'b0, '0},              // info timeout back to standby
      '{3'b000, 1'b0, '0},
      '{3'b000, 1'b0, '0},              // press taken
      '{3'b100, 1'b0, '0},              // silence too long, radio reinit
      '{3'b100, 1'b0, '0},
      '{3'b100, 1'b0, '0},
      '{3'b100, 1'b0, '0},
      '{3'b100, 1'b0, '0},
      '{3'b100, 1'b0, '0},              // single click: standby to detect
      '{3'b100, 1'b0, '0},              // spinner advances
      '{3'b011, 1'b0, '0},              // poll in detect while pressing
      '{3'b000, 1'b0, '0}
   };

   localparam phase_type PLAN [PHASES] = '{
      '{'{16'd2, 16'd12, 16'd10, 16'd3, 16'd40, 16'd30}, 200, 10, 0, 0, 1'b0, 1'b0, 1'b0},
      '{'{16'd5, 16'd30, 16'd25, 16'd7, 16'd80, 16'd60}, 200, 8, 86, 0, 1'b0, 1'b0, 1'b0},
      '{'{16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 200, 30, 0, 86, 1'b0, 1'b0, 1'b0},
      '{'{16'd1, 16'd8, 16'd4, 16'd1, 16'd20, 16'd15}, 200, 10, 23, 23, 1'b0, 1'b0, 1'b0},
      '{'{16'd3, 16'd20, 16'd6, 16'd2, 16'd30, 16'd100}, 200, 5, 0, 0, 1'b1, 1'b1, 1'b0},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 50, 0, 0, 0,
        1'b0, 1'b0, 1'b1},
      '{'{DEBOUNCE_RST, DOUBLE_CLICK_RST, SEND_HOLD_RST, SPIN_PERIOD_RST, INFO_TIMEOUT_RST,
          STALL_RST}, 300, 3, 23, 23, 1'b0, 1'b0, 1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_button_level = 1'b1;
   logic                 req_packet_heard = 1'b0;
   logic                 req_poll_heard = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_mode;
   logic                 rsp_send_screen;
   logic [FRAME_W-1:0]   rsp_spinner_frame;
   logic                 rsp_reply_request;
   logic                 rsp_reply_shown;
   logic                 rsp_radio_reinit;
   logic                 rsp_redraw;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEBOUNCE;
   logic [CFG_W-1:0]     csr_data = '0;

   // typed expectation travels with the item it belongs to
   logic       row_typed = 1'b0;
   result_type row_want = '0;

   result_type due_results [$];
   int         errors = 0;
   int         idle_cycles = 0;
   int         rx_stall_pct = 0;
   int         squeeze_asked = 0;
   int         squeeze_served = 0;
   int         squeeze_left = 0;

   // sender idle share for the running phase
   int         tx_idle_pct = 0;

   // controller state as the testbench sees it
   cfg_type          shadow_cfg = '{DEBOUNCE_RST, DOUBLE_CLICK_RST, SEND_HOLD_RST,
                                    SPIN_PERIOD_RST, INFO_TIMEOUT_RST, STALL_RST};
   logic             last_sample = 1'b1;
   logic             held_level = 1'b1;
   logic             second_pending = 1'b0;
   logic             screen_hold = 1'b0;
   logic [CNT_W-1:0] bounce_cnt = '0;
   logic [CNT_W-1:0] click_cnt = '0;
   logic [CNT_W-1:0] hold_cnt = '0;
   logic [CNT_W-1:0] spin_cnt = '0;
   logic [CNT_W-1:0] info_cnt = '0;
   logic [CNT_W-1:0] quiet_cnt = '0;
   mode_type         cur_mode = MD_STANDBY;
   logic [FRAME_W-1:0] frame = '0;

   button_click_mode_controller_unit uut (.*);

   always #2 clock = ~clock;

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // one millisecond tick of the controller
   function automatic result_type step_controller(item_type it);
      result_type r;
      r = '0;
      bounce_cnt = sat_inc(bounce_cnt);
      click_cnt = sat_inc(click_cnt);
      hold_cnt = sat_inc(hold_cnt);
      spin_cnt = sat_inc(spin_cnt);
      info_cnt = sat_inc(info_cnt);
      quiet_cnt = sat_inc(quiet_cnt);

      // packet and poll
      if (it.packet_heard) begin
         quiet_cnt = '0;
         if (it.poll_heard) begin
            r.reply_request = 1'b1;
            if (cur_mode != MD_INFO) begin
               cur_mode = MD_DETECT;
               r.reply_shown = 1'b1;
               screen_hold = 1'b1;
               hold_cnt = '0;
               r.redraw = 1'b1;
            end
         end
      end

      // radio silence
      if (quiet_cnt > shadow_cfg.stall_ticks) begin
         r.radio_reinit = 1'b1;
         quiet_cnt = '0;
      end

      // debounce, then first or second press
      if (it.button_level != last_sample)
         bounce_cnt = '0;
      if (bounce_cnt > shadow_cfg.debounce_ticks && it.button_level != held_level) begin
         held_level = it.button_level;
         if (!it.button_level) begin
            if (second_pending && click_cnt < shadow_cfg.double_click_ticks) begin
               second_pending = 1'b0;
               cur_mode = MD_INFO;
               info_cnt = '0;
               r.redraw = 1'b1;
            end else begin
               second_pending = 1'b1;
               click_cnt = '0;
            end
         end
      end
      last_sample = it.button_level;

      // window ran out: single click
      if (second_pending && click_cnt >= shadow_cfg.double_click_ticks) begin
         second_pending = 1'b0;
         if (cur_mode == MD_STANDBY) begin
            cur_mode = MD_DETECT;
            screen_hold = 1'b0;
            frame = '0;
            spin_cnt = '0;
         end else begin
            cur_mode = MD_STANDBY;
         end
         r.redraw = 1'b1;
      end

      // per-mode timers
      case (cur_mode)
         MD_DETECT: begin
            if (screen_hold) begin
               if (hold_cnt > shadow_cfg.send_hold_ticks) begin
                  screen_hold = 1'b0;
                  frame = '0;
                  spin_cnt = '0;
                  r.redraw = 1'b1;
               end
            end else if (spin_cnt > shadow_cfg.spin_period_ticks) begin
               frame = frame + 1'b1;
               spin_cnt = '0;
               r.redraw = 1'b1;
            end
         end
         MD_INFO: begin
            if (info_cnt >= shadow_cfg.info_timeout_ticks) begin
               cur_mode = MD_STANDBY;
               r.redraw = 1'b1;
            end
         end
         default: ;
      endcase

      r.mode = cur_mode;
      r.send_screen = (cur_mode == MD_DETECT) && screen_hold;
      r.spinner_frame = frame;
      return r;
   endfunction

   task automatic check_field(string label, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         errors++;
      end
   endtask

   // results against expectations, register writes and accepted items
   always @(posedge clock) begin
      result_type want;
      result_type fresh;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: result item with nothing expected, mode %0d", $time, rsp_mode);
               errors++;
            end else begin
               want = due_results.pop_front();
               check_field("mode", want.mode, rsp_mode);
               check_field("send_screen", want.send_screen, rsp_send_screen);
               check_field("spinner_frame", want.spinner_frame, rsp_spinner_frame);
               check_field("reply_request", want.reply_request, rsp_reply_request);
               check_field("reply_shown", want.reply_shown, rsp_reply_shown);
               check_field("radio_reinit", want.radio_reinit, rsp_radio_reinit);
               check_field("redraw", want.redraw, rsp_redraw);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE:     shadow_cfg.debounce_ticks = csr_data;
               CSR_DOUBLE_CLICK: shadow_cfg.double_click_ticks = csr_data;
               CSR_SEND_HOLD:    shadow_cfg.send_hold_ticks = csr_data;
               CSR_SPIN_PERIOD:  shadow_cfg.spin_period_ticks = csr_data;
               CSR_INFO_TIMEOUT: shadow_cfg.info_timeout_ticks = csr_data;
               CSR_STALL:        shadow_cfg.stall_ticks = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            fresh = step_controller('{req_button_level, req_packet_heard, req_poll_heard});
            due_results.push_back(row_typed ? row_want : fresh);
         end
      end
   end

   // result side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (squeeze_left != 0) begin
         squeeze_left <= squeeze_left - 1;
         rsp_ready <= 1'b0;
      end else if (squeeze_asked != squeeze_served) begin
         squeeze_served <= squeeze_asked;
         squeeze_left <= SQUEEZE_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_button_click_mode_controller_unit: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int PLAN_IDLE_PCT();
      return tx_idle_pct;
   endfunction

   task automatic send_tick(item_type it, logic typed, result_type want);
      while ($urandom_range(0, 99) < PLAN_IDLE_PCT()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_button_level <= it.button_level;
      req_packet_heard <= it.packet_heard;
      req_poll_heard <= it.poll_heard;
      row_typed <= typed;
      row_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait until every item in flight has come back
   task automatic drain();
      @(posedge clock);
      while (due_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_regs(cfg_type c, bit stray);
      logic [CSR_IDX_W-1:0] idx [$];
      logic [CFG_W-1:0]     val [$];
      idx.push_back(CSR_DEBOUNCE);     val.push_back(c.debounce_ticks);
      idx.push_back(CSR_DOUBLE_CLICK); val.push_back(c.double_click_ticks);
      idx.push_back(CSR_SEND_HOLD);    val.push_back(c.send_hold_ticks);
      idx.push_back(CSR_SPIN_PERIOD);  val.push_back(c.spin_period_ticks);
      idx.push_back(CSR_INFO_TIMEOUT); val.push_back(c.info_timeout_ticks);
      idx.push_back(CSR_STALL);        val.push_back(c.stall_ticks);
      if (stray) begin
         idx.push_back(CSR_SPARE_LO); val.push_back(CFG_W'($urandom_range(0, 65535)));
         idx.push_back(CSR_SPARE_HI); val.push_back(CFG_W'($urandom_range(0, 65535)));
      end
      foreach (idx[k]) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      phase_type ph;
      item_type  it;
      logic      level;
      int        run_left;
      int        dbt;
      int        dc;
      int        rest_max;
      level = 1'b1;
      run_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows, short timers loaded after the reset-value rows
      for (int i = 0; i < STEP_ROWS; i++) begin
         if (i == RETUNE_ROW) begin
            req_valid <= 1'b0;
            drain();
            write_regs(TUNE_CFG, 1'b0);
         end
         send_tick(STEPS[i].tick, STEPS[i].typed, STEPS[i].want);
      end
      req_valid <= 1'b0;

      // random phases, each with its own timer setting and idling
      for (int p = 0; p < PHASES; p++) begin
         ph = PLAN[p];
         drain();
         write_regs(ph.cfg, ph.stray);
         tx_idle_pct = ph.tx_idle;
         rx_stall_pct = ph.rx_stall;
         if (ph.squeeze)
            squeeze_asked++;
         dbt = int'(ph.cfg.debounce_ticks);
         dc = int'(ph.cfg.double_click_ticks);
         rest_max = int'(ph.cfg.info_timeout_ticks) + int'(ph.cfg.send_hold_ticks);
         if (rest_max > 200)
            rest_max = 200;
         for (int n = 0; n < ph.n_items; n++) begin
            if (ph.long_quiet) begin
               // one poll, then a held press and no packets under the widest thresholds
               it.button_level = (n == 0);
               it.packet_heard = (n == 0);
               it.poll_heard = (n == 0) || ($urandom_range(0, 1) == 1);
            end else begin
               // button as runs: clean presses and releases, bounces, long rests
               if (run_left == 0) begin
                  level = ~level;
                  if (dbt > 0 && $urandom_range(0, 9) < 3)
                     run_left = $urandom_range(1, dbt);
                  else if ($urandom_range(0, 9) == 0)
                     run_left = dbt + 1 + $urandom_range(0, rest_max);
                  else
                     run_left = dbt + 1 + $urandom_range(0, dc);
               end
               run_left--;
               it.button_level = level;
               it.packet_heard = ($urandom_range(0, 99) < ph.pkt_pct);
               it.poll_heard = ($urandom_range(0, 99) < (it.packet_heard ? 30 : 5));
            end
            send_tick(it, 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      drain();
      repeat (DRAIN_SLACK) @(posedge clock);
      if (errors == 0 && due_results.size() == 0) begin
         $display("tb_button_click_mode_controller_unit: done, clean");
      end else begin
         $display("tb_button_click_mode_controller_unit: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/bcm_pkg.sv
src/bcm_csr.sv
src/bcm_core.sv
src/button_click_mode_controller_unit.sv
tb/tb_button_click_mode_controller_unit.sv
